[sv/sgpcd_pkg.sv]
`timescale 1ns / 1ps
// Package of the SPI GPIO/PWM command decoder: item and state types,
// command field codes and reset values. Used by every module of the block.
package sgpcd_pkg;

  localparam int RxW    = 8;
  localparam int PinW   = 3;
  localparam int ChW    = 3;
  localparam int InDataW  = 48;
  localparam int OutDataW = 80;

  typedef enum logic {
    OPC_CMD = 1'b0,
    OPC_ADC = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    SEL_NONE   = 3'd0,
    SEL_DDR_B  = 3'd1,
    SEL_DDR_C  = 3'd2,
    SEL_DDR_D  = 3'd3,
    SEL_PORT_B = 3'd4,
    SEL_PORT_C = 3'd5,
    SEL_PORT_D = 3'd6,
    SEL_SPARE  = 3'd7
  } sel_t;

  localparam logic [PinW-1:0] PWM0_PIN = 3'd6;
  localparam logic [PinW-1:0] PWM1_PIN = 3'd1;

  localparam logic [RxW-1:0] CMD_PWM0_PIN_OUT = 8'hDE;
  localparam logic [RxW-1:0] CMD_PWM1_PIN_OUT = 8'hC9;

  localparam logic [RxW-1:0] TX_ZERO = 8'h00;
  localparam logic [RxW-1:0] TX_ONE  = 8'h01;

  typedef struct packed {
    opcode_t          opcode;
    logic [RxW-1:0]   rx_byte;
    logic [7:0]       pin_levels_b;
    logic [7:0]       pin_levels_c;
    logic [7:0]       pin_levels_d;
    logic [ChW-1:0]   adc_channel;
    logic [7:0]       adc_value;
  } item_t;

  typedef struct packed {
    logic [7:0] dir_b;
    logic [7:0] dir_c;
    logic [7:0] dir_d;
    logic [7:0] out_b;
    logic [7:0] out_c;
    logic [7:0] out_d;
    logic [7:0] duty0;
    logic [7:0] duty1;
    logic [2:0] clk_sel0;
    logic [2:0] clk_sel1;
    logic       en0;
    logic       en1;
    logic       pend_armed;
    logic       pend_ch;
  } io_state_t;

  localparam io_state_t ST_RESET = '{
    dir_b: 8'h13, dir_c: 8'h00, dir_d: 8'h00,
    out_b: 8'h00, out_c: 8'h00, out_d: 8'hFC,
    duty0: 8'h00, duty1: 8'h00,
    clk_sel0: 3'd0, clk_sel1: 3'd0,
    en0: 1'b0, en1: 1'b0,
    pend_armed: 1'b0, pend_ch: 1'b0
  };

  typedef struct packed {
    logic           has_result;
    logic [RxW-1:0] tx_byte;
  } dec_res_t;

endpackage

[sv/sgpcd_adc_store.sv]
`timescale 1ns / 1ps
// Stored ADC samples: one register per channel, one write port,
// one read port that replies zero beyond the channel count. Uses sgpcd_pkg.
module sgpcd_adc_store #(
  parameter int CHANNEL_COUNT = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [sgpcd_pkg::ChW-1:0] wr_ch,
  input  logic [7:0]                wr_data,
  input  logic [sgpcd_pkg::ChW-1:0] rd_ch,
  output logic [7:0]                rd_data
);

  localparam int IdxW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [sgpcd_pkg::ChW:0] Count = (sgpcd_pkg::ChW + 1)'(CHANNEL_COUNT);

  logic [7:0] sample_r [CHANNEL_COUNT];
  logic       wr_hit;
  logic       rd_hit;

  assign wr_hit = wr_en && ({1'b0, wr_ch} < Count);
  assign rd_hit = {1'b0, rd_ch} < Count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        sample_r[i] <= '0;
      end
    end else if (wr_hit) begin
      sample_r[wr_ch[IdxW-1:0]] <= wr_data;
    end
  end

  assign rd_data = rd_hit ? sample_r[rd_ch[IdxW-1:0]] : sgpcd_pkg::TX_ZERO;

endmodule

[sv/sgpcd_decode.sv]
`timescale 1ns / 1ps
// Command decode: next I/O state and reply byte for one registered item.
// Purely combinational; uses sgpcd_pkg types and codes.
module sgpcd_decode (
  input  sgpcd_pkg::item_t     item,
  input  sgpcd_pkg::io_state_t st,
  input  logic [7:0]           adc_rd_data,
  output sgpcd_pkg::io_state_t st_nxt,
  output sgpcd_pkg::dec_res_t  res
);

  function automatic sgpcd_pkg::io_state_t write_pin(sgpcd_pkg::io_state_t s,
                                                     logic [7:0] b);
    sgpcd_pkg::io_state_t r;
    logic [2:0]           pin;
    logic                 v;
    r   = s;
    pin = b[2:0];
    v   = b[6];
    case (sgpcd_pkg::sel_t'(b[5:3]))
      sgpcd_pkg::SEL_DDR_B: begin
        if (pin == sgpcd_pkg::PWM1_PIN) begin
          r.duty1    = '0;
          r.clk_sel1 = '0;
          r.en1      = 1'b0;
        end
        r.dir_b[pin] = v;
      end
      sgpcd_pkg::SEL_DDR_C: r.dir_c[pin] = v;
      sgpcd_pkg::SEL_DDR_D: begin
        if (pin == sgpcd_pkg::PWM0_PIN) begin
          r.duty0    = '0;
          r.clk_sel0 = '0;
          r.en0      = 1'b0;
        end
        r.dir_d[pin] = v;
      end
      sgpcd_pkg::SEL_PORT_B: r.out_b[pin] = v;
      sgpcd_pkg::SEL_PORT_C: r.out_c[pin] = v;
      sgpcd_pkg::SEL_PORT_D: r.out_d[pin] = v;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic level_of(logic [7:0] dir, logic [7:0] latch,
                                    logic [7:0] pins, logic [2:0] pin);
    return dir[pin] ? latch[pin] : pins[pin];
  endfunction

  logic [7:0]      b;
  sgpcd_pkg::sel_t sel;

  assign b   = item.rx_byte;
  assign sel = sgpcd_pkg::sel_t'(b[5:3]);

  always_comb begin
    st_nxt         = st;
    res.has_result = (item.opcode == sgpcd_pkg::OPC_CMD);
    res.tx_byte    = b;
    if (item.opcode == sgpcd_pkg::OPC_ADC) begin
      res.has_result = 1'b0;
    end else if (st.pend_armed && (b != '0)) begin
      if (!st.pend_ch) begin
        st_nxt.duty0 = b;
      end else begin
        st_nxt.duty1 = b;
      end
      st_nxt.pend_armed = 1'b0;
      st_nxt.pend_ch    = 1'b0;
    end else if (b[7]) begin
      st_nxt = write_pin(st, b);
    end else if (b[6] && (sel == sgpcd_pkg::SEL_NONE)) begin
      res.tx_byte = adc_rd_data;
    end else if (b[6]) begin
      if (b[5]) begin
        if (b[3]) begin
          if (!b[4]) begin
            if (st.en0) begin
              res.tx_byte = sgpcd_pkg::TX_ZERO;
            end else begin
              st_nxt          = write_pin(st, sgpcd_pkg::CMD_PWM0_PIN_OUT);
              st_nxt.clk_sel0 = b[2:0];
              st_nxt.en0      = 1'b1;
              res.tx_byte     = sgpcd_pkg::TX_ONE;
            end
          end else begin
            if (st.en1) begin
              res.tx_byte = sgpcd_pkg::TX_ZERO;
            end else begin
              st_nxt          = write_pin(st, sgpcd_pkg::CMD_PWM1_PIN_OUT);
              st_nxt.clk_sel1 = b[2:0];
              st_nxt.en1      = 1'b1;
              res.tx_byte     = sgpcd_pkg::TX_ONE;
            end
          end
        end else begin
          st_nxt.pend_armed = 1'b1;
          st_nxt.pend_ch    = b[4];
        end
      end
    end else begin
      case (sel)
        sgpcd_pkg::SEL_PORT_B:
          res.tx_byte = {7'b0, level_of(st.dir_b, st.out_b, item.pin_levels_b, b[2:0])};
        sgpcd_pkg::SEL_PORT_C:
          res.tx_byte = {7'b0, level_of(st.dir_c, st.out_c, item.pin_levels_c, b[2:0])};
        sgpcd_pkg::SEL_PORT_D:
          res.tx_byte = {7'b0, level_of(st.dir_d, st.out_d, item.pin_levels_d, b[2:0])};
        default: res.tx_byte = sgpcd_pkg::TX_ZERO;
      endcase
    end
  end

endmodule

[sv/spi_gpio_pwm_command_decoder_unit.sv]
`timescale 1ns / 1ps
// Top level of the SPI GPIO/PWM command decoder: input register, I/O state,
// result register. Depends on sgpcd_pkg, sgpcd_adc_store and sgpcd_decode.
//
// Usage:
//   in_*  channel: one transfer per SPI command byte or ADC sample update.
//         in_tuser is the opcode (0 = command byte, 1 = sample update).
//   out_* channel: one transfer per command byte, carrying the reply byte
//         and a snapshot of direction, latch and PWM settings after it.
//         Sample updates produce no output transfer.
//   Path: an accepted item waits in the input register and is then decoded
//   into the result register, which drives out_tvalid.
//   Throughput: one item per cycle unless out_tready stalls; the state
//   update and decode of each item are combinational between the registers.
//   Stall: while out_tvalid is held by a low out_tready, the item in the
//   input register waits; in_tready stays high as long as the input
//   register is empty or moves on in the same cycle.
//   Reset: synchronous on rst_n low; both registers empty, port state and
//   samples return to their power-up values, PWM channels stopped and no
//   duty arm pending.
module spi_gpio_pwm_command_decoder_unit #(
  parameter int CHANNEL_COUNT = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // rx_byte, pin_levels_b, pin_levels_c, pin_levels_d, adc_channel, adc_value
  input  logic [sgpcd_pkg::InDataW-1:0]     in_tdata,
  // opcode
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tx_byte, ddr_b, ddr_c, ddr_d, port_b, port_c, port_d, pwm0_duty,
  // pwm1_duty, pwm0_clock_select, pwm1_clock_select, pwm_enables
  output logic [sgpcd_pkg::OutDataW-1:0]    out_tdata
);

  logic                 in_vld_r;
  logic                 in_vld_nxt;
  sgpcd_pkg::item_t     item_r;
  sgpcd_pkg::item_t     item_nxt;
  sgpcd_pkg::io_state_t st_r;
  sgpcd_pkg::io_state_t st_nxt;
  sgpcd_pkg::dec_res_t  res;
  logic                 out_vld_r;
  logic                 out_vld_nxt;
  logic [sgpcd_pkg::OutDataW-1:0] out_data_r;
  logic [sgpcd_pkg::OutDataW-1:0] out_data_nxt;
  logic                 fire;
  logic                 in_xfer;
  logic [7:0]           adc_rd_data;
  logic                 adc_wr;

  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;
  assign in_xfer   = in_tvalid && in_tready;
  assign adc_wr    = fire && (item_r.opcode == sgpcd_pkg::OPC_ADC);

  always_comb begin
    item_nxt.opcode       = sgpcd_pkg::opcode_t'(in_tuser);
    item_nxt.rx_byte      = in_tdata[7:0];
    item_nxt.pin_levels_b = in_tdata[15:8];
    item_nxt.pin_levels_c = in_tdata[23:16];
    item_nxt.pin_levels_d = in_tdata[31:24];
    item_nxt.adc_channel  = in_tdata[34:32];
    item_nxt.adc_value    = in_tdata[42:35];
  end

  sgpcd_adc_store #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_adc_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (adc_wr),
    .wr_ch   (item_r.adc_channel),
    .wr_data (item_r.adc_value),
    .rd_ch   (item_r.rx_byte[2:0]),
    .rd_data (adc_rd_data)
  );

  sgpcd_decode u_decode (
    .item        (item_r),
    .st          (st_r),
    .adc_rd_data (adc_rd_data),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  always_comb begin
    in_vld_nxt = in_xfer ? 1'b1 : (fire ? 1'b0 : in_vld_r);
    if (fire && res.has_result) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
    out_data_nxt = {2'b00 | {st_nxt.en1, st_nxt.en0},
                    st_nxt.clk_sel1, st_nxt.clk_sel0,
                    st_nxt.duty1, st_nxt.duty0,
                    st_nxt.out_d, st_nxt.out_c, st_nxt.out_b,
                    st_nxt.dir_d, st_nxt.dir_c, st_nxt.dir_b,
                    res.tx_byte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= sgpcd_pkg::ST_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (fire) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= item_nxt;
    end
    if (fire && res.has_result) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_clk_sel0_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.en0 |-> (st_r.clk_sel0 == '0))
    else $error("PWM0 clock select set while channel disabled");

  a_clk_sel1_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.en1 |-> (st_r.clk_sel1 == '0))
    else $error("PWM1 clock select set while channel disabled");

  a_disarm: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (item_r.opcode == sgpcd_pkg::OPC_CMD) && st_r.pend_armed &&
    (item_r.rx_byte != '0) |=> !st_r.pend_armed)
    else $error("duty arm not cleared after duty byte");

  a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !fire |=> in_vld_r && $stable(item_r))
    else $error("input register lost a waiting item");

endmodule
